// File: sv/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// shared constants, types and node word helpers for the max-xor trie
// ----------------------------------------------------------------------------
package btmx_pkg;

   // field widths
   localparam int KEY_W = 32;
   localparam int XOR_W = 32;

   // trie geometry
   localparam int KEY_BITS   = 32;
   localparam int NODE_DEPTH = 32768;
   localparam int IDX_W      = $clog2(NODE_DEPTH);
   localparam int CNT_W      = IDX_W + 1;
   localparam int SUM_W      = CNT_W + 1;
   localparam int WORD_W     = 2 * IDX_W;
   localparam int LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

   // command codes
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_QUERY  = 1'b1;

   // status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [WORD_W-1:0] word_type;
   typedef logic [LVL_W-1:0]  lvl_type;

   // node store access
   typedef struct packed {
      logic     rd_en;
      idx_type  rd_addr;
      logic     wr_en;
      idx_type  wr_addr;
      word_type wr_data;
   } store_req_type;

   // digit path control
   typedef struct packed {
      logic load;
      logic key_shift;
      logic lvl_dec;
      logic acc_shift;
      logic acc_bit;
   } digit_ctl_type;

   // child index for one branch; upper half is the one-child
   function automatic idx_type child_sel(input word_type word, input logic branch);
      child_sel = branch ? word[WORD_W-1:IDX_W] : word[IDX_W-1:0];
   endfunction

   // replace one branch of a node word
   function automatic word_type child_set(input word_type word, input logic branch,
                                          input idx_type idx);
      word_type res;
      res = word;
      if (branch) begin
         res[WORD_W-1:IDX_W] = idx;
      end else begin
         res[IDX_W-1:0] = idx;
      end
      child_set = res;
   endfunction

endpackage

// File: sv/btmx_digit.sv
// ----------------------------------------------------------------------------
// btmx_digit
// bit-serial key path: key shift register, result shift register, level count
// ----------------------------------------------------------------------------
module btmx_digit (
   input  logic                   clock,
   input  logic                   reset,
   input  btmx_pkg::digit_ctl_type ctl,
   input  logic [btmx_pkg::KEY_BITS-1:0] key_load,
   output logic                   key_bit,
   output btmx_pkg::lvl_type      lvl,
   output logic                   lvl_zero,
   output logic [btmx_pkg::KEY_BITS-1:0] acc
);
   import btmx_pkg::*;

   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] acc_ff, acc_in;
   lvl_type             lvl_ff, lvl_in;

   // next values of the shift registers
   always_comb begin
      key_in = key_ff;
      acc_in = acc_ff;
      lvl_in = lvl_ff;
      if (ctl.load) begin
         key_in = key_load;
         acc_in = '0;
         lvl_in = LVL_W'(KEY_BITS - 1);
      end else begin
         if (ctl.key_shift) begin
            key_in = key_ff << 1;
         end
         if (ctl.acc_shift) begin
            acc_in = (acc_ff << 1) | KEY_BITS'(ctl.acc_bit);
         end
         if (ctl.lvl_dec) begin
            lvl_in = lvl_ff - LVL_W'(1);
         end
      end
   end

   // level counter is control state, shift registers are payload
   always_ff @(posedge clock) begin
      if (reset) begin
         lvl_ff <= '0;
      end else begin
         lvl_ff <= lvl_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      acc_ff <= acc_in;
   end

   assign key_bit  = key_ff[KEY_BITS-1];
   assign lvl      = lvl_ff;
   assign lvl_zero = (lvl_ff == '0);
   assign acc      = acc_ff;

endmodule

// File: sv/btmx_store.sv
// ----------------------------------------------------------------------------
// btmx_store
// node store: root word in flops, other nodes in a one-read one-write memory
// ----------------------------------------------------------------------------
module btmx_store (
   input  logic                    clock,
   input  logic                    reset,
   input  btmx_pkg::store_req_type req,
   output btmx_pkg::word_type      root_word,
   output btmx_pkg::word_type      rd_data
);
   import btmx_pkg::*;

   word_type mem [NODE_DEPTH];
   word_type root_ff;
   word_type rd_data_ff;

   // root is cleared by reset, its index never appears as a child
   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else if (req.wr_en && (req.wr_addr == '0)) begin
         root_ff <= req.wr_data;
      end
   end

   // node memory, registered read
   always_ff @(posedge clock) begin
      if (req.wr_en && (req.wr_addr != '0)) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= mem[req.rd_addr];
      end
   end

   assign root_word = root_ff;
   assign rd_data   = rd_data_ff;

endmodule

// File: sv/binary_trie_max_xor.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor
// binary trie of unsigned keys with insert and maximum-xor query
// ----------------------------------------------------------------------------
//  channel   ports                                 handshake
//  request   req_cmd, req_key                      start high while busy low
//  response  rsp_max_xor, rsp_found, rsp_status    rsp_strobe for one cycle
//
//  one key bit per cycle, one node read or write per cycle on the node memory
//  query: walk the key bits, then a done state; response strobe as busy drops
//  insert: walk the stored path, one check, one link write, then one write
//  per new node; a duplicate key answers from the walk, a full store from
//  the check; empty-trie query answers next cycle
//  synchronous reset empties the trie; results cannot be stalled
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic                        req_cmd,
   input  logic [btmx_pkg::KEY_W-1:0]  req_key,
   output logic                        rsp_strobe,
   output logic [btmx_pkg::XOR_W-1:0]  rsp_max_xor,
   output logic                        rsp_found,
   output logic                        rsp_status
);
   import btmx_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_WALK  = 6'b000010,
      ST_QDONE = 6'b000100,
      ST_CHECK = 6'b001000,
      ST_LINK  = 6'b010000,
      ST_FILL  = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic                cmd_ff, cmd_in;
   logic                first_ff, first_in;
   idx_type             node_ff, node_in;
   word_type            brk_word_ff, brk_word_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic                present_ff, present_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [XOR_W-1:0]    rsp_max_xor_ff, rsp_max_xor_in;
   logic                rsp_found_ff, rsp_found_in;
   logic                rsp_status_ff, rsp_status_in;

   store_req_type       sreq;
   digit_ctl_type       dctl;
   word_type            root_word, rd_data, word_cur;
   logic                key_bit, lvl_zero;
   lvl_type             lvl;
   logic [KEY_BITS-1:0] acc;
   idx_type             opp_idx, same_idx, next_idx, new_idx;
   logic                take_opp, overflow;
   logic [SUM_W-1:0]    need_sum;

   btmx_digit u_digit (
      .clock    (clock),
      .reset    (reset),
      .ctl      (dctl),
      .key_load (req_key[KEY_BITS-1:0]),
      .key_bit  (key_bit),
      .lvl      (lvl),
      .lvl_zero (lvl_zero),
      .acc      (acc)
   );

   btmx_store u_store (
      .clock     (clock),
      .reset     (reset),
      .req       (sreq),
      .root_word (root_word),
      .rd_data   (rd_data)
   );

   // current node word and branch choice
   always_comb begin
      word_cur = first_ff ? root_word : rd_data;
      opp_idx  = child_sel(word_cur, ~key_bit);
      same_idx = child_sel(word_cur, key_bit);
      take_opp = (opp_idx != '0);
      next_idx = take_opp ? opp_idx : same_idx;
      new_idx  = used_ff[IDX_W-1:0];
      need_sum = SUM_W'(used_ff) + SUM_W'(lvl) + SUM_W'(1);
      overflow = (need_sum > SUM_W'(NODE_DEPTH));
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      first_in       = first_ff;
      node_in        = node_ff;
      brk_word_in    = brk_word_ff;
      used_in        = used_ff;
      present_in     = present_ff;
      rsp_strobe_in  = 1'b0;
      rsp_max_xor_in = rsp_max_xor_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_status_in  = rsp_status_ff;
      sreq           = '0;
      dctl           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if ((req_cmd == CMD_QUERY) && !present_ff) begin
                  // empty trie answers at once
                  rsp_strobe_in  = 1'b1;
                  rsp_max_xor_in = '0;
                  rsp_found_in   = 1'b0;
                  rsp_status_in  = STATUS_OK;
               end else begin
                  dctl.load = 1'b1;
                  cmd_in    = req_cmd;
                  first_in  = 1'b1;
                  node_in   = '0;
                  state_in  = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (cmd_ff == CMD_QUERY) begin
               // prefer the opposite branch
               dctl.key_shift = 1'b1;
               dctl.lvl_dec   = 1'b1;
               dctl.acc_shift = 1'b1;
               dctl.acc_bit   = take_opp;
               if (lvl_zero) begin
                  state_in = ST_QDONE;
               end else begin
                  sreq.rd_en   = 1'b1;
                  sreq.rd_addr = next_idx;
                  node_in      = next_idx;
                  first_in     = 1'b0;
               end
            end else if (same_idx == '0) begin
               // first missing child: remember the node and size the fill
               brk_word_in = word_cur;
               state_in    = ST_CHECK;
            end else if (lvl_zero) begin
               // key already stored
               present_in     = 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_max_xor_in = '0;
               rsp_found_in   = 1'b0;
               rsp_status_in  = STATUS_OK;
               state_in       = ST_IDLE;
            end else begin
               dctl.key_shift = 1'b1;
               dctl.lvl_dec   = 1'b1;
               sreq.rd_en     = 1'b1;
               sreq.rd_addr   = same_idx;
               node_in        = same_idx;
               first_in       = 1'b0;
            end
         end

         ST_QDONE: begin
            rsp_strobe_in  = 1'b1;
            rsp_max_xor_in = XOR_W'(acc);
            rsp_found_in   = 1'b1;
            rsp_status_in  = STATUS_OK;
            state_in       = ST_IDLE;
         end

         ST_CHECK: begin
            if (overflow) begin
               rsp_strobe_in  = 1'b1;
               rsp_max_xor_in = '0;
               rsp_found_in   = 1'b0;
               rsp_status_in  = STATUS_FULL;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_LINK;
            end
         end

         ST_LINK: begin
            // hook the first new node under the existing node
            sreq.wr_en     = 1'b1;
            sreq.wr_addr   = node_ff;
            sreq.wr_data   = child_set(brk_word_ff, key_bit, new_idx);
            dctl.key_shift = 1'b1;
            state_in       = ST_FILL;
         end

         ST_FILL: begin
            // each new node points at the next, the last one is a leaf
            sreq.wr_en   = 1'b1;
            sreq.wr_addr = new_idx;
            used_in      = used_ff + CNT_W'(1);
            if (lvl_zero) begin
               sreq.wr_data   = '0;
               present_in     = 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_max_xor_in = '0;
               rsp_found_in   = 1'b0;
               rsp_status_in  = STATUS_OK;
               state_in       = ST_IDLE;
            end else begin
               sreq.wr_data   = child_set('0, key_bit, new_idx + IDX_W'(1));
               dctl.key_shift = 1'b1;
               dctl.lvl_dec   = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         used_ff       <= CNT_W'(1);
         present_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         present_ff    <= present_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      first_ff       <= first_in;
      node_ff        <= node_in;
      brk_word_ff    <= brk_word_in;
      rsp_max_xor_ff <= rsp_max_xor_in;
      rsp_found_ff   <= rsp_found_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_max_xor = rsp_max_xor_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for binary_trie_max_xor
// drives insert and query words through the start/busy port, keeps its own
// trie of the accepted keys and checks every response word field by field;
// the random part fills the node store until inserts are refused, then keeps
// going with near keys, duplicates and queries on the full trie
// ----------------------------------------------------------------------------
module testbench;

   import btmx_pkg::*;

   localparam int     HALF_PERIOD = 4;
   localparam int     RESET_CYCLES = 6;
   localparam longint LIMIT_NS = 64'd12_000_000;
   localparam int     DRAIN_CYCLES = 4000;
   localparam int     TAIL_CYCLES = 2 * KEY_BITS + 8;
   localparam logic [63:0] KEY_MASK = (64'd1 << KEY_BITS) - 64'd1;

   typedef struct {
      logic             cmd;
      logic [KEY_W-1:0] key;
   } trie_word_type;

   typedef struct {
      logic             cmd;
      logic [KEY_W-1:0] key;
      logic [XOR_W-1:0] max_xor;
      logic             found;
      logic             status;
   } answer_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             req_cmd = CMD_INSERT;
   logic [KEY_W-1:0] req_key = '0;
   logic             busy;
   logic             rsp_strobe;
   logic [XOR_W-1:0] rsp_max_xor;
   logic             rsp_found;
   logic             rsp_status;

   // words still to be sent, and answers owed by the block
   trie_word_type words_waiting[$];
   answer_type    answers_due[$];

   // shadow trie: child links per node, zero means no child
   int unsigned      kid0 [NODE_DEPTH];
   int unsigned      kid1 [NODE_DEPTH];
   int unsigned      node_count;
   logic             stored_any;
   logic [KEY_W-1:0] kept_keys[$];

   int unsigned n_inserts, n_refused, n_queries, n_empty_queries, n_checked, faults;
   int unsigned gap_left, burst_left;

   binary_trie_max_xor dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .req_key     (req_key),
      .rsp_strobe  (rsp_strobe),
      .rsp_max_xor (rsp_max_xor),
      .rsp_found   (rsp_found),
      .rsp_status  (rsp_status)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // insert into the shadow trie; returns 0 when the store cannot take the key
   function automatic logic trie_add(input logic [KEY_W-1:0] key);
      int unsigned node, nxt, need;
      int          lvl;
      node = 0;
      need = 0;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = key[lvl] ? kid1[node] : kid0[node];
         if (nxt == 0) begin
            need = lvl + 1;
            break;
         end
         node = nxt;
      end
      if (node_count + need > NODE_DEPTH) begin
         return 1'b0;
      end
      // second walk hangs the fresh nodes onto the path
      node = 0;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         nxt = key[lvl] ? kid1[node] : kid0[node];
         if (nxt == 0) begin
            nxt = node_count;
            kid0[nxt] = 0;
            kid1[nxt] = 0;
            node_count++;
            if (key[lvl]) begin
               kid1[node] = nxt;
            end else begin
               kid0[node] = nxt;
            end
         end
         node = nxt;
      end
      stored_any = 1'b1;
      kept_keys.push_back(key);
      return 1'b1;
   endfunction

   // greedy walk toward the opposite bit gives the largest xor
   function automatic logic [XOR_W-1:0] trie_best_xor(input logic [KEY_W-1:0] key);
      int unsigned      node, far, near;
      int               lvl;
      logic [XOR_W-1:0] acc;
      node = 0;
      acc = '0;
      for (lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
         far = key[lvl] ? kid0[node] : kid1[node];
         if (far != 0) begin
            acc[lvl] = 1'b1;
            node = far;
         end else begin
            near = key[lvl] ? kid1[node] : kid0[node];
            if (near == 0) begin
               break;
            end
            node = near;
         end
      end
      return acc;
   endfunction

   function automatic logic [KEY_W-1:0] pick_kept();
      if (kept_keys.size() == 0) begin
         return $urandom;
      end
      return kept_keys[$urandom_range(0, kept_keys.size() - 1)];
   endfunction

   task automatic queue_word(input logic cmd, input logic [KEY_W-1:0] key);
      trie_word_type w;
      w.cmd = cmd;
      w.key = key;
      words_waiting.push_back(w);
   endtask

   // one random word; after the store is full the mix leans on near keys
   task automatic queue_random_word(input bit store_full);
      int unsigned      r;
      logic [KEY_W-1:0] qkey;
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
         0: qkey = $urandom;
         1: qkey = pick_kept();
         2: qkey = ~pick_kept();
         default: qkey = pick_kept() ^ $urandom_range(0, 255);
      endcase
      if (!store_full) begin
         if (r < 88) begin
            queue_word(CMD_INSERT, $urandom);
         end else if (r < 90) begin
            queue_word(CMD_INSERT, pick_kept());
         end else begin
            queue_word(CMD_QUERY, qkey);
         end
      end else begin
         if (r < 25) begin
            queue_word(CMD_INSERT, $urandom);
         end else if (r < 45) begin
            queue_word(CMD_INSERT, pick_kept() ^ (32'd1 << $urandom_range(0, 7)));
         end else if (r < 60) begin
            queue_word(CMD_INSERT, pick_kept());
         end else begin
            queue_word(CMD_QUERY, qkey);
         end
      end
   endtask

   // driver: predicts each accepted word, then bursts or idles
   always @(posedge clock) begin
      logic             took;
      logic [KEY_W-1:0] key_used;
      answer_type       due;
      trie_word_type    nxt;
      if (reset) begin
         start <= 1'b0;
         req_cmd <= CMD_INSERT;
         req_key <= '0;
         kid0[0] = 0;
         kid1[0] = 0;
         node_count = 1;
         stored_any = 1'b0;
         gap_left = 0;
         burst_left = 1;
      end else begin
         took = start && !busy;
         if (took) begin
            key_used = req_key & KEY_MASK[KEY_W-1:0];
            due.cmd = req_cmd;
            due.key = req_key;
            due.max_xor = '0;
            due.found = 1'b0;
            due.status = STATUS_OK;
            if (req_cmd == CMD_INSERT) begin
               n_inserts++;
               if (!trie_add(key_used)) begin
                  due.status = STATUS_FULL;
                  n_refused++;
               end
            end else begin
               n_queries++;
               if (stored_any) begin
                  due.max_xor = trie_best_xor(key_used);
                  due.found = 1'b1;
               end else begin
                  n_empty_queries++;
               end
            end
            answers_due.push_back(due);
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = $urandom_range(1, 90);
            end else if ($urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(1, 40);
            end
         end else if (!start && gap_left != 0) begin
            gap_left--;
         end
         // a word still waiting for acceptance stays on the port untouched
         if (!start || took) begin
            if (gap_left == 0 && words_waiting.size() != 0) begin
               nxt = words_waiting.pop_front();
               start <= 1'b1;
               req_cmd <= nxt.cmd;
               req_key <= nxt.key;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor: every strobed word against the oldest answer owed
   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_strobe) begin
         if (answers_due.size() == 0) begin
            $error("response with nothing outstanding: max_xor %h found %b status %b",
                   rsp_max_xor, rsp_found, rsp_status);
            faults++;
         end else begin
            due = answers_due.pop_front();
            n_checked++;
            if (rsp_max_xor !== due.max_xor) begin
               $error("max_xor (cmd %b key %h): expected %h, got %h",
                      due.cmd, due.key, due.max_xor, rsp_max_xor);
               faults++;
            end
            if (rsp_found !== due.found) begin
               $error("found (cmd %b key %h): expected %b, got %b",
                      due.cmd, due.key, due.found, rsp_found);
               faults++;
            end
            if (rsp_status !== due.status) begin
               $error("status (cmd %b key %h): expected %b, got %b",
                      due.cmd, due.key, due.status, rsp_status);
               faults++;
            end
         end
      end
   end

   // stimulus and end of run
   initial begin
      int w;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty trie, extremes, duplicates, single-node inserts
      queue_word(CMD_QUERY, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'hFFFF_FFFF);
      queue_word(CMD_INSERT, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'hFFFF_FFFF);
      queue_word(CMD_INSERT, 32'hFFFF_FFFF);
      queue_word(CMD_INSERT, 32'hFFFF_FFFF);
      queue_word(CMD_INSERT, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'h8000_0000);
      queue_word(CMD_INSERT, 32'h0000_0001);
      queue_word(CMD_INSERT, 32'h8000_0000);
      queue_word(CMD_INSERT, 32'h5555_5555);
      queue_word(CMD_INSERT, 32'hAAAA_AAAA);
      queue_word(CMD_QUERY, 32'h1234_5678);
      queue_word(CMD_QUERY, 32'h5555_5555);
      queue_word(CMD_INSERT, 32'h7FFF_FFFF);
      queue_word(CMD_QUERY, 32'h7FFF_FFFF);
      queue_word(CMD_QUERY, 32'h0000_0000);

      // fill the node store in chunks until an insert gets refused
      while (n_refused == 0 && n_inserts < 2500) begin
         repeat (40) queue_random_word(1'b0);
         while (words_waiting.size() != 0) @(posedge clock);
      end
      // full store: refusals, near keys that may still fit, queries
      repeat (160) queue_random_word(1'b1);
      queue_word(CMD_QUERY, 32'h0000_0000);
      queue_word(CMD_QUERY, 32'hFFFF_FFFF);

      while (words_waiting.size() != 0 || start) @(posedge clock);
      for (w = 0; w < DRAIN_CYCLES && answers_due.size() != 0; w++) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (answers_due.size() != 0) begin
         $error("%0d responses never arrived", answers_due.size());
         faults++;
      end

      $display("covered %0d inserts (%0d refused on a full store), %0d queries (%0d empty)",
               n_inserts, n_refused, n_queries, n_empty_queries);
      $display("%0d responses checked, %0d of %0d trie nodes in use",
               n_checked, node_count, NODE_DEPTH);
      if (faults == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d words unsent and %0d responses owed",
               words_waiting.size(), answers_due.size());
      $display("simulation failed");
      $finish;
   end

endmodule
